/* sv/aes_pkg.sv */
// Shared types, constants and round functions for the AES block cipher core.
// Depends on nothing; used by aes_ctrl, aes_dpath and aes_block_cipher_core.
package aes_pkg;

	localparam int KeyWordsDefault = 4;
	localparam int IdxW = 6;   // key schedule word counter, up to word 59 (60 words)
	localparam int StepW = 4;  // round step counter, up to 14 rounds
	localparam int CfgIdxW = 8;

	localparam logic [CfgIdxW-1:0] REG_KEY_PART0 = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_PART1 = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_PART2 = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_PART3 = 8'd3;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef struct packed {
		logic             load;
		logic             kx_go;
		logic             kx_first;
		logic             kx_key;
		logic             kx_rot;
		logic             kx_sub;
		logic             kx_wr;
		logic [IdxW-1:0]  kx_idx;
		logic             rd_go;
		logic [StepW-1:0] rd_step;
		logic             rnd_go;
		logic             rnd_first;
		logic             rnd_last;
		logic             out_load;
	} aes_cmd_t;

	typedef struct packed {
		logic sched_ready;
		logic busy;
	} aes_stat_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte n of the state sits at bits 127-8n down
	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		o = '0;
		for (int n = 0; n < 16; n++)
			o[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		int src;
		o = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
				o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
			end
		return o;
	endfunction

	// coefficient select: 0 -> 02/0e, 1 -> 03/0b, 2 -> 01/0d, 3 -> 01/09
	function automatic logic [7:0] gf_coef(input logic [7:0] a, input int sel,
			input logic inv);
		logic [7:0] x2, x4, x8, o;
		x2 = xtime(a);
		x4 = xtime(x2);
		x8 = xtime(x4);
		case (sel)
			0: o = inv ? (x8 ^ x4 ^ x2) : x2;
			1: o = inv ? (x8 ^ x2 ^ a) : (x2 ^ a);
			2: o = inv ? (x8 ^ x4 ^ a) : a;
			default: o = inv ? (x8 ^ a) : a;
		endcase
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] acc;
		o = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = '0;
				for (int k = 0; k < 4; k++)
					acc = acc ^ gf_coef(s[127-8*(4*c+k) -: 8], (k - r + 4) % 4, inv);
				o[127-8*(4*c+r) -: 8] = acc;
			end
		return o;
	endfunction

endpackage

/* sv/aes_ctrl.sv */
// Sequencer for the AES core: schedule expansion, round stepping and output beat.
// Depends on aes_pkg; drives aes_dpath through aes_pkg::aes_cmd_t.
module aes_ctrl #(
	parameter int KEY_WORDS = aes_pkg::KeyWordsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic                key_wr,
	output aes_pkg::aes_cmd_t   cmd,
	output aes_pkg::aes_stat_t  stat
);

	localparam int NumRounds = KEY_WORDS + 6;
	localparam int StoreWords = 4 * (KEY_WORDS + 7);
	localparam logic [aes_pkg::StepW-1:0] LastStep = aes_pkg::StepW'(NumRounds);
	localparam logic [aes_pkg::IdxW-1:0] LastIdx = aes_pkg::IdxW'(StoreWords - 1);
	localparam logic [aes_pkg::IdxW-1:0] KeyW = aes_pkg::IdxW'(KEY_WORDS);
	localparam logic [2:0] LastMod = 3'(KEY_WORDS - 1);

	typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_READ, S_RUN, S_FIN} state_t;

	state_t                   state_q;
	logic [aes_pkg::IdxW-1:0]  idx_q;
	logic [2:0]               mod_q;
	logic [aes_pkg::StepW-1:0] step_q;
	logic                     ready_q;
	logic                     in_stall_q;
	logic                     out_valid_q;
	logic                     accept;
	logic                     out_free;

	assign accept = in_valid && !in_stall_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = in_stall_q;
	assign out_valid = out_valid_q;
	assign stat.sched_ready = ready_q;
	assign stat.busy = in_stall_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && accept;
		cmd.kx_go = (state_q == S_EXPAND);
		cmd.kx_first = (idx_q == '0);
		cmd.kx_key = (idx_q < KeyW);
		cmd.kx_rot = (mod_q == 3'd0) && (idx_q >= KeyW);
		cmd.kx_sub = (KEY_WORDS > 6) && (mod_q == 3'd4);
		cmd.kx_wr = (idx_q[1:0] == 2'd3);
		cmd.kx_idx = idx_q;
		cmd.rd_go = (state_q == S_READ) || ((state_q == S_RUN) && (step_q != LastStep));
		cmd.rd_step = (state_q == S_READ) ? '0 : step_q + 1'b1;
		cmd.rnd_go = (state_q == S_RUN);
		cmd.rnd_first = (step_q == '0);
		cmd.rnd_last = (step_q == LastStep);
		cmd.out_load = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			mod_q <= '0;
			step_q <= '0;
			ready_q <= 1'b0;
			in_stall_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new beat into the output register, or drop the one taken
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (key_wr)
				ready_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_stall_q <= 1'b1;
						idx_q <= '0;
						mod_q <= '0;
						state_q <= ready_q ? S_READ : S_EXPAND;
					end
				end
				S_EXPAND: begin
					idx_q <= idx_q + 1'b1;
					mod_q <= (mod_q == LastMod) ? 3'd0 : mod_q + 1'b1;
					if (idx_q == LastIdx) begin
						if (!key_wr)
							ready_q <= 1'b1;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					step_q <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LastStep)
						state_q <= S_FIN;
				end
				S_FIN: begin
					// hold the result until the output register is free
					if (out_free) begin
						in_stall_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/aes_dpath.sv */
// Datapath for the AES core: key expansion window, round-key store, state and result.
// Depends on aes_pkg; steered by aes_ctrl through aes_pkg::aes_cmd_t.
module aes_dpath #(
	parameter int KEY_WORDS = aes_pkg::KeyWordsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aes_pkg::aes_cmd_t      cmd,
	input  logic [3:0][63:0]       key,
	input  logic                   func,
	input  logic [63:0]            block_hi,
	input  logic [63:0]            block_lo,
	output logic [63:0]            result_hi,
	output logic [63:0]            result_lo
);

	localparam int NumRounds = KEY_WORDS + 6;
	localparam int Rows = NumRounds + 1;
	localparam int RowW = $clog2(Rows);
	localparam logic [aes_pkg::StepW-1:0] LastStep = aes_pkg::StepW'(NumRounds);

	logic [127:0] rk_mem [Rows];
	logic [127:0] rk_q;
	logic [31:0]  win_q [KEY_WORDS];
	logic [95:0]  row_q;
	logic [7:0]   rc_q;
	logic [127:0] st_q;
	logic [127:0] res_q;
	logic         enc_q;

	logic [31:0]  key_word;
	logic [31:0]  tmp_word;
	logic [31:0]  new_word;
	logic [aes_pkg::StepW-1:0] rd_addr;
	logic [127:0] enc_t, dec_t, rnd_out;

	always_comb begin
		key_word = cmd.kx_idx[0] ? key[cmd.kx_idx[2:1]][31:0] : key[cmd.kx_idx[2:1]][63:32];
		tmp_word = win_q[KEY_WORDS-1];
		if (cmd.kx_rot)
			tmp_word = aes_pkg::sub_word({tmp_word[23:0], tmp_word[31:24]}) ^ {rc_q, 24'h0};
		else if (cmd.kx_sub)
			tmp_word = aes_pkg::sub_word(tmp_word);
		new_word = cmd.kx_key ? key_word : (win_q[0] ^ tmp_word);
	end

	always_ff @(posedge clk) begin
		if (cmd.kx_go) begin
			for (int j = 0; j < KEY_WORDS - 1; j++)
				win_q[j] <= win_q[j+1];
			win_q[KEY_WORDS-1] <= new_word;
			row_q <= {row_q[63:0], new_word};
			if (cmd.kx_first)
				rc_q <= aes_pkg::RCON_FIRST;
			else if (cmd.kx_rot)
				rc_q <= aes_pkg::xtime(rc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kx_go && cmd.kx_wr)
			rk_mem[RowW'(cmd.kx_idx[aes_pkg::IdxW-1:2])] <= {row_q, new_word};
		if (cmd.rd_go)
			rk_q <= rk_mem[rd_addr[RowW-1:0]];
	end

	// decryption walks the store from the top
	assign rd_addr = enc_q ? cmd.rd_step : (LastStep - cmd.rd_step);

	always_comb begin
		enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_q, 1'b0), 1'b0);
		if (!cmd.rnd_last)
			enc_t = aes_pkg::mix_columns(enc_t, 1'b0);
		enc_t = enc_t ^ rk_q;
		dec_t = aes_pkg::sub_bytes(aes_pkg::shift_rows(st_q, 1'b1), 1'b1) ^ rk_q;
		if (!cmd.rnd_last)
			dec_t = aes_pkg::mix_columns(dec_t, 1'b1);
		if (cmd.rnd_first)
			rnd_out = st_q ^ rk_q;
		else
			rnd_out = enc_q ? enc_t : dec_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q <= 1'b0;
		end else if (cmd.load) begin
			enc_q <= func;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			st_q <= {block_hi, block_lo};
		else if (cmd.rnd_go)
			st_q <= rnd_out;
		if (cmd.out_load)
			res_q <= st_q;
	end

	assign result_hi = res_q[127:64];
	assign result_lo = res_q[63:0];

endmodule

/* sv/aes_block_cipher_core.sv */
// Top level of the AES block cipher core: key registers, sequencer and datapath.
// Depends on aes_pkg, aes_ctrl and aes_dpath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (key parts)
//  in       | in_valid / in_stall   | func, block_hi, block_lo
//  out      | out_valid / out_stall | result_hi, result_lo
//
// After accept the core prefetches the first round key from the store, then
// steps one round per cycle through the single round unit, then loads the
// output register; the next block is accepted once the core is back in idle.
// After reset or any key write, the first block first expands the schedule,
// one word a cycle: 4*(KEY_WORDS+7) words in all (44 at 128-bit keys).
// One block is in flight at a time; in_stall stays high until its result has
// moved into the output register, which holds while out_stall is high.
module aes_block_cipher_core #(
	parameter int KEY_WORDS = aes_pkg::KeyWordsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [63:0]                 block_hi,
	input  logic [63:0]                 block_lo,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [63:0]                 result_hi,
	output logic [63:0]                 result_lo
);

	logic [3:0][63:0]   key_q;
	logic               key_wr;
	aes_pkg::aes_cmd_t  cmd;
	aes_pkg::aes_stat_t stat;

	assign cfg_ready = 1'b1;
	assign key_wr = cfg_valid && cfg_ready &&
		(cfg_index == aes_pkg::REG_KEY_PART0 || cfg_index == aes_pkg::REG_KEY_PART1 ||
		 cfg_index == aes_pkg::REG_KEY_PART2 || cfg_index == aes_pkg::REG_KEY_PART3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_wr) begin
			key_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	aes_ctrl #(.KEY_WORDS(KEY_WORDS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_wr    (key_wr),
		.cmd       (cmd),
		.stat      (stat)
	);

	aes_dpath #(.KEY_WORDS(KEY_WORDS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (key_q),
		.func      (func),
		.block_hi  (block_hi),
		.block_lo  (block_lo),
		.result_hi (result_hi),
		.result_lo (result_lo)
	);

	a_key_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr |=> !stat.sched_ready)
		else $error("key write did not invalidate the schedule");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> stat.busy)
		else $error("accepted block did not make the core busy");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.busy) && !stat.busy)
		else $error("result appeared without a block in flight");

	a_run_needs_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rnd_go |-> stat.sched_ready)
		else $error("round stepped on an unexpanded schedule");

endmodule
